[rtl/core/wavi2s_pkg.sv]
package wavi2s_pkg;

    // result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_FRAME  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_BAD_TAG     = 3'd1;
    localparam logic [2:0] ERR_FMT_SMALL   = 3'd2;
    localparam logic [2:0] ERR_NO_FMT      = 3'd3;
    localparam logic [2:0] ERR_UNSUPPORTED = 3'd4;
    localparam logic [2:0] ERR_TRUNCATED   = 3'd5;

    // chunk tags, big-endian as they arrive
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [15:0] FORMAT_PCM  = 16'd1;
    localparam logic [15:0] SAMPLE_BITS = 16'd16;
    localparam logic [31:0] FMT_BODY_LEN = 32'd16;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] left_sample;
        logic signed [31:0] right_sample;
        logic [31:0]        rate_hz;
        logic [15:0]        channel_count;
        logic [31:0]        data_length;
        logic [2:0]         error_code;
        logic               last;
    } result_t;

endpackage

[rtl/core/wavi2s_parser.sv]
module wavi2s_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           data_byte,
    input  logic                 first_byte,
    input  logic                 end_of_file,
    output logic                 res_valid,
    output wavi2s_pkg::result_t  res
);
    import wavi2s_pkg::*;

    localparam logic [2:0] PH_RIFF = 3'd0;
    localparam logic [2:0] PH_HDR  = 3'd1;
    localparam logic [2:0] PH_FMT  = 3'd2;
    localparam logic [2:0] PH_SKIP = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;

    logic [2:0]  phase_reg,    phase_next,    cur_phase;
    logic [3:0]  cnt_reg,      cnt_next,      cur_cnt;
    logic [31:0] tag_reg,      tag_next,      cur_tag;
    logic [31:0] len_reg,      len_next,      cur_len;
    logic [15:0] format_reg,   format_next,   cur_format;
    logic [15:0] channels_reg, channels_next, cur_channels;
    logic [31:0] rate_reg,     rate_next,     cur_rate;
    logic [15:0] bits_reg,     bits_next,     cur_bits;
    logic        seen_reg,     seen_next,     cur_seen;
    logic [31:0] remain_reg,   remain_next,   cur_remain;
    logic [23:0] sbytes_reg,   sbytes_next,   cur_sbytes;
    logic [1:0]  idx_reg,      idx_next,      cur_idx;

    logic [31:0] tag_shift;
    logic [31:0] fmt_extra;
    logic        mono;
    logic        frame_last;

    function automatic result_t error_result(input logic [2:0] code);
        result_t r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    always_comb
    begin
        // first_byte restarts from the reset state
        cur_phase    = first_byte ? PH_RIFF : phase_reg;
        cur_cnt      = first_byte ? 4'd0    : cnt_reg;
        cur_tag      = first_byte ? 32'd0   : tag_reg;
        cur_len      = first_byte ? 32'd0   : len_reg;
        cur_format   = first_byte ? 16'd0   : format_reg;
        cur_channels = first_byte ? 16'd0   : channels_reg;
        cur_rate     = first_byte ? 32'd0   : rate_reg;
        cur_bits     = first_byte ? 16'd0   : bits_reg;
        cur_seen     = first_byte ? 1'b0    : seen_reg;
        cur_remain   = first_byte ? 32'd0   : remain_reg;
        cur_sbytes   = first_byte ? 24'd0   : sbytes_reg;
        cur_idx      = first_byte ? 2'd0    : idx_reg;

        phase_next    = cur_phase;
        cnt_next      = cur_cnt;
        tag_next      = cur_tag;
        len_next      = cur_len;
        format_next   = cur_format;
        channels_next = cur_channels;
        rate_next     = cur_rate;
        bits_next     = cur_bits;
        seen_next     = cur_seen;
        remain_next   = cur_remain;
        sbytes_next   = cur_sbytes;
        idx_next      = cur_idx;

        tag_shift  = {cur_tag[23:0], data_byte};
        fmt_extra  = cur_len - FMT_BODY_LEN;
        mono       = (cur_channels == 16'd1);
        frame_last = 1'b0;

        res_valid = 1'b0;
        res       = '0;

        unique case (cur_phase)
            PH_RIFF:
            begin
                tag_next = tag_shift;
                // len doubles as the bad RIFF tag flag here
                if (cur_cnt == 4'd3 && tag_shift != TAG_RIFF)
                begin
                    len_next = 32'd1;
                end
                if (cur_cnt >= 4'd11)
                begin
                    if (len_next != 32'd0 || tag_shift != TAG_WAVE)
                    begin
                        phase_next = PH_DONE;
                        res_valid  = 1'b1;
                        res        = error_result(ERR_BAD_TAG);
                    end
                    else
                    begin
                        phase_next = PH_HDR;
                        cnt_next   = 4'd0;
                        len_next   = 32'd0;
                    end
                end
                else
                begin
                    cnt_next = cur_cnt + 4'd1;
                end
            end
            PH_HDR:
            begin
                if (cur_cnt < 4'd4)
                begin
                    tag_next = tag_shift;
                end
                else if (cur_cnt == 4'd4)
                begin
                    len_next = {24'd0, data_byte};
                end
                else
                begin
                    len_next = cur_len | ({24'd0, data_byte} << {cur_cnt[1:0], 3'b000});
                end
                if (cur_cnt >= 4'd7)
                begin
                    cnt_next = 4'd0;
                    if (tag_next == TAG_FMT)
                    begin
                        if (len_next < FMT_BODY_LEN)
                        begin
                            phase_next = PH_DONE;
                            res_valid  = 1'b1;
                            res        = error_result(ERR_FMT_SMALL);
                        end
                        else
                        begin
                            phase_next = PH_FMT;
                        end
                    end
                    else if (tag_next == TAG_DATA)
                    begin
                        if (!cur_seen)
                        begin
                            phase_next = PH_DONE;
                            res_valid  = 1'b1;
                            res        = error_result(ERR_NO_FMT);
                        end
                        else
                        begin
                            res_valid         = 1'b1;
                            res.rate_hz       = cur_rate;
                            res.channel_count = cur_channels;
                            res.data_length   = len_next;
                            if (cur_format != FORMAT_PCM || cur_bits != SAMPLE_BITS
                                || (cur_channels != 16'd1 && cur_channels != 16'd2))
                            begin
                                phase_next     = PH_DONE;
                                res.kind       = KIND_ERROR;
                                res.error_code = ERR_UNSUPPORTED;
                            end
                            else
                            begin
                                res.kind    = KIND_HEADER;
                                remain_next = len_next;
                                sbytes_next = 24'd0;
                                idx_next    = 2'd0;
                                phase_next  = (len_next != 32'd0) ? PH_DATA : PH_DONE;
                            end
                        end
                    end
                    else
                    begin
                        // skip an unknown chunk, plus its pad byte
                        remain_next = len_next;
                        phase_next  = (len_next == 32'd0 && !len_next[0]) ? PH_HDR : PH_SKIP;
                    end
                end
                else
                begin
                    cnt_next = cur_cnt + 4'd1;
                end
            end
            PH_FMT:
            begin
                unique case (cur_cnt)
                    4'd0:    format_next[7:0]    = data_byte;
                    4'd1:    format_next[15:8]   = data_byte;
                    4'd2:    channels_next[7:0]  = data_byte;
                    4'd3:    channels_next[15:8] = data_byte;
                    4'd4:    rate_next[7:0]      = data_byte;
                    4'd5:    rate_next[15:8]     = data_byte;
                    4'd6:    rate_next[23:16]    = data_byte;
                    4'd7:    rate_next[31:24]    = data_byte;
                    4'd14:   bits_next[7:0]      = data_byte;
                    4'd15:   bits_next[15:8]     = data_byte;
                    default: ;
                endcase
                if (cur_cnt == 4'd15)
                begin
                    seen_next   = 1'b1;
                    cnt_next    = 4'd0;
                    remain_next = fmt_extra;
                    phase_next  = (fmt_extra == 32'd0 && !cur_len[0]) ? PH_HDR : PH_SKIP;
                end
                else
                begin
                    cnt_next = cur_cnt + 4'd1;
                end
            end
            PH_SKIP:
            begin
                if (cur_remain != 32'd0)
                begin
                    remain_next = cur_remain - 32'd1;
                end
                else
                begin
                    len_next[0] = 1'b0;
                end
                if (remain_next == 32'd0 && !len_next[0])
                begin
                    phase_next = PH_HDR;
                    cnt_next   = 4'd0;
                end
            end
            PH_DATA:
            begin
                remain_next = cur_remain - 32'd1;
                frame_last  = (mono ? (remain_next < 32'd2) : (remain_next < 32'd4))
                              || end_of_file;
                if (mono && cur_idx == 2'd1)
                begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_FRAME;
                    res.left_sample  = {data_byte, cur_sbytes[7:0], 16'd0};
                    res.right_sample = {data_byte, cur_sbytes[7:0], 16'd0};
                    res.last         = frame_last;
                    idx_next         = 2'd0;
                end
                else if (!mono && cur_idx == 2'd3)
                begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_FRAME;
                    res.left_sample  = {cur_sbytes[15:0], 16'd0};
                    res.right_sample = {data_byte, cur_sbytes[23:16], 16'd0};
                    res.last         = frame_last;
                    idx_next         = 2'd0;
                end
                else
                begin
                    unique case (cur_idx)
                        2'd0:    sbytes_next[7:0]   = data_byte;
                        2'd1:    sbytes_next[15:8]  = data_byte;
                        2'd2:    sbytes_next[23:16] = data_byte;
                        default: ;
                    endcase
                    idx_next = cur_idx + 2'd1;
                end
                if (remain_next == 32'd0)
                begin
                    phase_next = PH_DONE;
                end
            end
            default: ;
        endcase

        if (end_of_file)
        begin
            // header never completed
            if (!res_valid && (cur_phase == PH_RIFF || cur_phase == PH_HDR
                               || cur_phase == PH_FMT || cur_phase == PH_SKIP))
            begin
                res_valid = 1'b1;
                res       = error_result(ERR_TRUNCATED);
            end
            phase_next = PH_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_RIFF;
            cnt_reg      <= 4'd0;
            tag_reg      <= 32'd0;
            len_reg      <= 32'd0;
            format_reg   <= 16'd0;
            channels_reg <= 16'd0;
            rate_reg     <= 32'd0;
            bits_reg     <= 16'd0;
            seen_reg     <= 1'b0;
            remain_reg   <= 32'd0;
            sbytes_reg   <= 24'd0;
            idx_reg      <= 2'd0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            tag_reg      <= tag_next;
            len_reg      <= len_next;
            format_reg   <= format_next;
            channels_reg <= channels_next;
            rate_reg     <= rate_next;
            bits_reg     <= bits_next;
            seen_reg     <= seen_next;
            remain_reg   <= remain_next;
            sbytes_reg   <= sbytes_next;
            idx_reg      <= idx_next;
        end
    end

`ifndef SYNTHESIS
    a_frame_from_data: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_valid && res.kind == KIND_FRAME)
            |=> (phase_reg == PH_DATA || phase_reg == PH_DONE))
        else $error("frame emitted outside data chunk");

    a_error_ends_parse: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_valid && res.kind == KIND_ERROR) |=> (phase_reg == PH_DONE))
        else $error("parser kept running after error");

    a_eof_ends_parse: assert property (@(posedge clk) disable iff (!rst_n)
        (step && end_of_file) |=> (phase_reg == PH_DONE))
        else $error("parser kept running after end of file");

    a_mono_index: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA && channels_reg == 16'd1) |-> (idx_reg <= 2'd1))
        else $error("mono sample index out of range");
`endif

endmodule

[rtl/core/wav_pcm16_to_i2s_frames.sv]
// path: an accepted byte waits in the input register stage, is parsed once the
//   output stage can take a result, and its result (if any) is registered there
// throughput: one byte per cycle when not stalled; all chunk state updates in one pass
// results appear for the header, each completed frame, or an error; other bytes none
// reset (rst_n, async, active low) empties both register stages and puts the
//   parser at file offset zero; first_byte also restarts parsing at any time
module wav_pcm16_to_i2s_frames (
    input  logic               clk,
    input  logic               rst_n,
    // byte channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               first_byte,
    input  logic               end_of_file,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic signed [31:0] left_sample,
    output logic signed [31:0] right_sample,
    output logic [31:0]        rate_hz,
    output logic [15:0]        channel_count,
    output logic [31:0]        data_length,
    output logic [2:0]         error_code,
    output logic               last
);
    import wavi2s_pkg::*;

    // input register stage
    logic       in_valid_reg, in_valid_next;
    logic [7:0] byte_reg;
    logic       first_reg;
    logic       eof_reg;

    // output register stage
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;

    logic       advance;   // output stage can take a new result
    logic       step;      // held byte goes through the parser this cycle
    logic       accept;    // new request taken into the input stage
    logic       res_valid;
    result_t    res;

    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    // input stage frees itself in the same cycle it hands its byte on
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    // a byte that causes no result simply leaves the output stage empty
    assign out_valid_next = advance ? (step && res_valid) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg  <= data_byte;
            first_reg <= first_byte;
            eof_reg   <= end_of_file;
        end
        if (step && res_valid)
        begin
            out_reg <= res;
        end
    end

    wavi2s_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (byte_reg),
        .first_byte  (first_reg),
        .end_of_file (eof_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    assign out_valid     = out_valid_reg;
    assign kind          = out_reg.kind;
    assign left_sample   = out_reg.left_sample;
    assign right_sample  = out_reg.right_sample;
    assign rate_hz       = out_reg.rate_hz;
    assign channel_count = out_reg.channel_count;
    assign data_length   = out_reg.data_length;
    assign error_code    = out_reg.error_code;
    assign last          = out_reg.last;

endmodule

[dv/tb_wav_pcm16_to_i2s_frames.sv]
`timescale 1ns / 1ps

module tb_wav_pcm16_to_i2s_frames;
    import wavi2s_pkg::*;

    // quiet cycles allowed before the run is declared hung
    localparam int WATCHDOG_CYCLES = 2000;
    // cycles to let the two register stages drain at the end
    localparam int DRAIN_CYCLES    = 8;

    // parser phases, mirrored from the block's behavior
    typedef enum logic [2:0] {
        PS_RIFF,
        PS_HDR,
        PS_FMT,
        PS_SKIP,
        PS_DATA,
        PS_DONE
    } parse_state_t;

    // what is wrong with a generated file
    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_TAG,
        FLAW_FMT_SMALL,
        FLAW_NO_FMT,
        FLAW_UNSUPPORTED,
        FLAW_CUT,
        FLAW_NOISE
    } file_flaw_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic [7:0]         data_byte    = 8'h00;
    logic               first_byte   = 1'b0;
    logic               end_of_file  = 1'b0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic [1:0]         kind;
    logic signed [31:0] left_sample;
    logic signed [31:0] right_sample;
    logic [31:0]        rate_hz;
    logic [15:0]        channel_count;
    logic [31:0]        data_length;
    logic [2:0]         error_code;
    logic               last;

    // predicted parser state
    parse_state_t wav_state   = PS_RIFF;
    logic [31:0]  hdr_count   = '0;
    logic [31:0]  tag_shift   = '0;
    logic [31:0]  chunk_len   = '0;
    logic [15:0]  fmt_code    = '0;
    logic [15:0]  chan_held   = '0;
    logic [31:0]  rate_held   = '0;
    logic [15:0]  bits_held   = '0;
    logic         fmt_found   = 1'b0;
    logic [31:0]  bytes_left  = '0;
    logic [23:0]  sample_hold = '0;
    logic [1:0]   sample_slot = '0;

    // results still owed by the block, oldest first
    result_t     wav_results_due[$];
    // bytes of the file being built
    logic [7:0]  file_bytes[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;
    int bytes_sent     = 0;
    int bytes_parsed   = 0;
    int files_sent     = 0;
    int headers_seen   = 0;
    int frames_seen    = 0;
    int errors_seen    = 0;

    wav_pcm16_to_i2s_frames u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .first_byte    (first_byte),
        .end_of_file   (end_of_file),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .left_sample   (left_sample),
        .right_sample  (right_sample),
        .rate_hz       (rate_hz),
        .channel_count (channel_count),
        .data_length   (data_length),
        .error_code    (error_code),
        .last          (last)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // byte parser prediction
    // ------------------------------------------------------------------

    // back to file offset zero
    function automatic void parse_restart();
        wav_state   = PS_RIFF;
        hdr_count   = '0;
        tag_shift   = '0;
        chunk_len   = '0;
        fmt_code    = '0;
        chan_held   = '0;
        rate_held   = '0;
        bits_held   = '0;
        fmt_found   = 1'b0;
        bytes_left  = '0;
        sample_hold = '0;
        sample_slot = '0;
    endfunction

    // terminal error: parser goes quiet until the next first byte
    function automatic bit parse_fail(input logic [2:0] code, output result_t res);
        wav_state      = PS_DONE;
        res            = '0;
        res.kind       = KIND_ERROR;
        res.error_code = code;
        return 1'b1;
    endfunction

    // skip a chunk body; bit 0 of the chunk size still owes a pad byte
    function automatic void parse_skip(input logic [31:0] count);
        bytes_left = count;
        hdr_count  = '0;
        wav_state  = (count == 0 && !chunk_len[0]) ? PS_HDR : PS_SKIP;
    endfunction

    // one byte in, at most one result out
    function automatic bit parse_wav_byte(input logic [7:0] b, input logic fb,
                                          input logic eof, output result_t res);
        parse_state_t entry_state;
        logic         mono;
        logic [31:0]  frame_bytes;
        logic [1:0]   slot;
        bit           got;
        got = 1'b0;
        res = '0;
        if (fb)
            parse_restart();
        entry_state = wav_state;
        if (entry_state != PS_DONE)
            bytes_parsed++;
        case (wav_state)
            PS_RIFF:
            begin
                tag_shift = {tag_shift[23:0], b};
                // a bad leading tag is held in the size register until byte 11
                if (hdr_count == 3 && tag_shift != TAG_RIFF)
                    chunk_len = 32'd1;
                if (hdr_count >= 11)
                begin
                    if (chunk_len != 0 || tag_shift != TAG_WAVE)
                        got = parse_fail(ERR_BAD_TAG, res);
                    else
                    begin
                        wav_state  = PS_HDR;
                        hdr_count  = '0;
                        chunk_len  = '0;
                    end
                end
                else
                    hdr_count++;
            end
            PS_HDR:
            begin
                if (hdr_count < 4)
                    tag_shift = {tag_shift[23:0], b};
                else if (hdr_count == 4)
                    chunk_len = {24'd0, b};
                else
                    chunk_len[8*hdr_count[1:0] +: 8] = b;
                if (hdr_count >= 7)
                begin
                    hdr_count = '0;
                    if (tag_shift == TAG_FMT)
                    begin
                        if (chunk_len < FMT_BODY_LEN)
                            got = parse_fail(ERR_FMT_SMALL, res);
                        else
                            wav_state = PS_FMT;
                    end
                    else if (tag_shift == TAG_DATA)
                    begin
                        if (!fmt_found)
                            got = parse_fail(ERR_NO_FMT, res);
                        else
                        begin
                            got               = 1'b1;
                            res.rate_hz       = rate_held;
                            res.channel_count = chan_held;
                            res.data_length   = chunk_len;
                            if (fmt_code != FORMAT_PCM || bits_held != SAMPLE_BITS ||
                                (chan_held != 16'd1 && chan_held != 16'd2))
                            begin
                                wav_state      = PS_DONE;
                                res.kind       = KIND_ERROR;
                                res.error_code = ERR_UNSUPPORTED;
                            end
                            else
                            begin
                                res.kind    = KIND_HEADER;
                                bytes_left  = chunk_len;
                                sample_hold = '0;
                                sample_slot = '0;
                                // empty data chunk: header only
                                wav_state   = (chunk_len != 0) ? PS_DATA : PS_DONE;
                            end
                        end
                    end
                    else
                        parse_skip(chunk_len);
                end
                else
                    hdr_count++;
            end
            PS_FMT:
            begin
                case (hdr_count)
                    0:          fmt_code[7:0]   = b;
                    1:          fmt_code[15:8]  = b;
                    2:          chan_held[7:0]  = b;
                    3:          chan_held[15:8] = b;
                    4, 5, 6, 7: rate_held[8*hdr_count[1:0] +: 8] = b;
                    14:         bits_held[7:0]  = b;
                    15:         bits_held[15:8] = b;
                    default:    ;
                endcase
                if (hdr_count >= 15)
                begin
                    fmt_found = 1'b1;
                    parse_skip(chunk_len - FMT_BODY_LEN);
                end
                else
                    hdr_count++;
            end
            PS_SKIP:
            begin
                if (bytes_left > 0)
                    bytes_left--;
                else
                    chunk_len[0] = 1'b0;
                if (bytes_left == 0 && !chunk_len[0])
                begin
                    wav_state = PS_HDR;
                    hdr_count = '0;
                end
            end
            PS_DATA:
            begin
                mono        = (chan_held == 16'd1);
                frame_bytes = mono ? 32'd2 : 32'd4;
                slot        = sample_slot;
                bytes_left--;
                if ((mono && slot == 2'd1) || (!mono && slot == 2'd3))
                begin
                    got      = 1'b1;
                    res.kind = KIND_FRAME;
                    if (mono)
                    begin
                        res.left_sample  = {b, sample_hold[7:0], 16'h0000};
                        res.right_sample = {b, sample_hold[7:0], 16'h0000};
                    end
                    else
                    begin
                        res.left_sample  = {sample_hold[15:0], 16'h0000};
                        res.right_sample = {b, sample_hold[23:16], 16'h0000};
                    end
                    // a trailing partial frame never shows, so flag this one
                    res.last    = (bytes_left < frame_bytes) || eof;
                    sample_slot = '0;
                end
                else
                begin
                    sample_hold[8*slot +: 8] = b;
                    sample_slot              = slot + 2'd1;
                end
                if (bytes_left == 0)
                    wav_state = PS_DONE;
            end
            default: ;
        endcase
        // end of file before the data chunk header is a truncated header
        if (eof)
        begin
            if (!got && entry_state != PS_DATA && entry_state != PS_DONE)
                got = parse_fail(ERR_TRUNCATED, res);
            wav_state = PS_DONE;
        end
        return got;
    endfunction

    // ------------------------------------------------------------------
    // byte channel
    // ------------------------------------------------------------------

    // one request on the byte channel; prediction happens on acceptance
    task automatic send_byte(input logic [7:0] b, input logic fb, input logic eof);
        result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        first_byte  <= fb;
        end_of_file <= eof;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        bytes_sent++;
        if (parse_wav_byte(b, fb, eof, res))
            wav_results_due.push_back(res);
    endtask

    task automatic send_file(input bit with_first, input bit with_eof);
        foreach (file_bytes[i])
            send_byte(file_bytes[i], with_first && i == 0,
                      with_eof && i == file_bytes.size() - 1);
        files_sent++;
    endtask

    // ------------------------------------------------------------------
    // file building
    // ------------------------------------------------------------------

    // biased toward the sample extremes
    function automatic logic [7:0] sample_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // tags go out in reading order
    function automatic void put_tag(input logic [31:0] t);
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back(t[8*i +: 8]);
    endfunction

    function automatic void put_le32(input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            file_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_le16(input logic [15:0] v);
        file_bytes.push_back(v[7:0]);
        file_bytes.push_back(v[15:8]);
    endfunction

    // an unknown chunk, odd sizes with their pad byte, now and then a huge one
    function automatic void put_other_chunk();
        logic [31:0] tag;
        logic [31:0] len;
        tag = $urandom;
        if (tag == TAG_FMT || tag == TAG_DATA)
            tag ^= 32'd1;
        len = ($urandom_range(15) == 0) ? $urandom : $urandom_range(0, 7);
        put_tag(tag);
        put_le32(len);
        repeat ((len < 8) ? len : $urandom_range(0, 8))
            file_bytes.push_back(sample_byte());
        if (len < 8 && len[0])
            file_bytes.push_back(sample_byte());
    endfunction

    task automatic make_wav_file(input file_flaw_t flaw);
        logic [31:0] riff_tag;
        logic [31:0] wave_tag;
        logic [31:0] fmt_len;
        logic [31:0] data_len;
        logic [31:0] rate;
        logic [15:0] fmt_tag;
        logic [15:0] chans;
        logic [15:0] bits;
        int          hdr_end;
        int          cut;
        file_bytes.delete();

        // garbage, sometimes behind a good riff header
        if (flaw == FLAW_NOISE)
        begin
            if ($urandom_range(1))
            begin
                put_tag(TAG_RIFF);
                put_le32($urandom);
                put_tag(TAG_WAVE);
            end
            repeat ($urandom_range(1, 20))
                file_bytes.push_back(sample_byte());
            return;
        end

        riff_tag = TAG_RIFF;
        wave_tag = TAG_WAVE;
        if (flaw == FLAW_BAD_TAG)
        begin
            case ($urandom_range(2))
                0:       riff_tag ^= 32'd1 << $urandom_range(31);
                1:       wave_tag ^= 32'd1 << $urandom_range(31);
                default:
                begin
                    riff_tag ^= 32'd1 << $urandom_range(31);
                    wave_tag ^= 32'd1 << $urandom_range(31);
                end
            endcase
        end
        put_tag(riff_tag);
        put_le32($urandom);
        put_tag(wave_tag);
        repeat ($urandom_range(0, 2))
            put_other_chunk();

        if (flaw != FLAW_NO_FMT)
        begin
            if (flaw == FLAW_FMT_SMALL)
                fmt_len = $urandom_range(0, 15);
            else
                fmt_len = ($urandom_range(3) == 0) ? $urandom_range(17, 21) : 16;
            fmt_tag = FORMAT_PCM;
            chans   = 16'($urandom_range(1, 2));
            bits    = SAMPLE_BITS;
            if (flaw == FLAW_UNSUPPORTED)
            begin
                case ($urandom_range(2))
                    0:       fmt_tag = $urandom_range(1) ? 16'd0 : 16'($urandom_range(2, 65535));
                    1:
                    begin
                        case ($urandom_range(2))
                            0:       chans = 16'd0;
                            1:       chans = 16'hFFFF;
                            default: chans = 16'($urandom_range(3, 65534));
                        endcase
                    end
                    default: bits = $urandom_range(1) ? 16'd8 : 16'($urandom_range(17, 65535));
                endcase
            end
            case ($urandom_range(4))
                0:       rate = 32'd0;
                1:       rate = 32'hFFFF_FFFF;
                2:       rate = 32'd44100;
                3:       rate = 32'd48000;
                default: rate = $urandom;
            endcase
            put_tag(TAG_FMT);
            put_le32(fmt_len);
            // the error fires at the header, the rest is ignored
            if (flaw == FLAW_FMT_SMALL)
            begin
                repeat ($urandom_range(0, 3))
                    file_bytes.push_back(sample_byte());
                return;
            end
            put_le16(fmt_tag);
            put_le16(chans);
            put_le32(rate);
            put_le32($urandom);
            put_le16(16'($urandom));
            put_le16(bits);
            // extra fmt bytes, then the pad byte if the size is odd
            repeat (fmt_len - 16)
                file_bytes.push_back(sample_byte());
            if (fmt_len[0])
                file_bytes.push_back(sample_byte());
            repeat ($urandom_range(0, 1))
                put_other_chunk();
        end

        case ($urandom_range(9))
            0:       data_len = 32'd0;
            1:       data_len = 32'hFFFF_FFFF;
            2:       data_len = $urandom;
            default: data_len = $urandom_range(1, 24);
        endcase
        put_tag(TAG_DATA);
        put_le32(data_len);
        hdr_end = file_bytes.size();

        // end of file somewhere before the data header completes
        if (flaw == FLAW_CUT)
        begin
            cut        = $urandom_range(1, hdr_end - 1);
            file_bytes = file_bytes[0:cut-1];
            return;
        end

        // short chunks: whole, cut short, or followed by ignored bytes;
        // long chunks just stop at end of file
        if (data_len <= 24)
        begin
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(0, data_len))
                    file_bytes.push_back(sample_byte());
            else
                repeat (data_len + $urandom_range(0, 2))
                    file_bytes.push_back(sample_byte());
        end
        else
            repeat ($urandom_range(0, 30))
                file_bytes.push_back(sample_byte());
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // right after reset the parser starts at offset zero without first_byte;
    // a bad riff tag shows only at byte 11, then everything is ignored
    task automatic test_parse_without_first_byte();
        file_bytes.delete();
        put_tag(TAG_RIFF ^ 32'h0000_001E);
        put_le32(32'hFF00_FF00);
        put_tag(TAG_WAVE);
        send_file(1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b1);
    endtask

    // end of file on the very first byte and inside the riff header
    task automatic test_truncated_header();
        send_byte(8'h00, 1'b1, 1'b1);
        file_bytes.delete();
        file_bytes.push_back(8'h52);
        file_bytes.push_back(8'h49);
        file_bytes.push_back(8'h46);
        send_file(1'b1, 1'b1);
    endtask

    // good files with random content; first_byte or end_of_file sometimes
    // missing so restarts and run-on files show up too
    task automatic test_well_formed_files(input int byte_budget);
        int start_count;
        start_count = bytes_sent;
        while (bytes_sent - start_count < byte_budget)
        begin
            make_wav_file(FLAW_NONE);
            send_file($urandom_range(19) != 0, $urandom_range(9) != 0);
        end
    endtask

    // every kind of broken file
    task automatic test_broken_files(input int byte_budget);
        int start_count;
        start_count = bytes_sent;
        while (bytes_sent - start_count < byte_budget)
        begin
            make_wav_file(file_flaw_t'($urandom_range(FLAW_BAD_TAG, FLAW_NOISE)));
            send_file($urandom_range(9) != 0, $urandom_range(5) != 0);
        end
    endtask

    // ------------------------------------------------------------------
    // result channel
    // ------------------------------------------------------------------

    // random back-pressure on results
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // compare each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (wav_results_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0d error %0d",
                         $time, kind, error_code);
                mismatches++;
            end
            else
            begin
                want = wav_results_due.pop_front();
                check_field("kind", want.kind, kind);
                check_field("left_sample", want.left_sample, left_sample);
                check_field("right_sample", want.right_sample, right_sample);
                check_field("rate_hz", want.rate_hz, rate_hz);
                check_field("channel_count", want.channel_count, channel_count);
                check_field("data_length", want.data_length, data_length);
                check_field("error_code", want.error_code, error_code);
                check_field("last", want.last, last);
                case (want.kind)
                    KIND_HEADER: headers_seen++;
                    KIND_FRAME:  frames_seen++;
                    default:     errors_seen++;
                endcase
            end
        end
    end

    // hang detection: no request moving on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("%0t: no request accepted for %0d cycles", $time, quiet_cycles);
            $display("wav_pcm16_to_i2s_frames regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        parse_restart();

        // sender mostly busy, receiver mostly stalled
        send_idle_pct  = 13;
        recv_stall_pct = 67;
        test_parse_without_first_byte();
        test_truncated_header();

        for (int mix = 0; mix < 3; mix++)
        begin
            case (mix)
                0:
                begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 67;
                end
                1:
                begin
                    send_idle_pct  = 67;
                    recv_stall_pct = 13;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            test_well_formed_files(480);
            test_broken_files(140);
        end
        in_valid <= 1'b0;

        // drain outstanding results, then give the pipeline time to misbehave
        while (wav_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d files, %0d bytes (%0d parsed), across three idle and stall mixes",
                 files_sent, bytes_sent, bytes_parsed);
        $display("checked %0d header reports, %0d stereo frames, %0d errors",
                 headers_seen, frames_seen, errors_seen);
        if (mismatches == 0)
            $display("wav_pcm16_to_i2s_frames regression: pass");
        else
            $display("wav_pcm16_to_i2s_frames regression: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/wavi2s_pkg.sv
rtl/core/wavi2s_parser.sv
rtl/core/wav_pcm16_to_i2s_frames.sv
dv/tb_wav_pcm16_to_i2s_frames.sv
